// File: hw/rtl/brt_pkg.sv
// Shared types, constants and gauge table for the battery report translator.
package brt_pkg;

   // Fixed byte positions and values within a report.
   localparam logic [4:0] POS_HEADER   = 5'd0;
   localparam logic [4:0] POS_CLASS    = 5'd2;
   localparam logic [4:0] POS_KIND     = 5'd3;
   localparam logic [4:0] POS_VOLT_HI  = 5'd4;
   localparam logic [4:0] POS_VOLT_LO  = 5'd5;
   localparam logic [4:0] POS_STATUS   = 5'd6;
   localparam logic [4:0] POS_MAX      = 5'd31;

   localparam logic [7:0] HEADER_BYTE  = 8'h11;
   localparam logic [7:0] CLASS_BYTE   = 8'h08;
   localparam logic [7:0] KIND_BYTE    = 8'h0a;
   localparam logic [7:0] CHARGE_BYTE  = 8'h03;

   // Piecewise-linear gauge: breakpoints from the top, in mV and percent.
   localparam int GAUGE_POINTS = 8;
   localparam logic [15:0] GAUGE_MV [GAUGE_POINTS] = '{
      16'd4100, 16'd3950, 16'd3850, 16'd3750,
      16'd3650, 16'd3500, 16'd3300, 16'd3150
   };
   localparam logic [6:0] GAUGE_PCT [GAUGE_POINTS] = '{
      7'd100, 7'd80, 7'd60, 7'd40, 7'd20, 7'd10, 7'd5, 7'd0
   };

   // Scaling geometry: the quotient never exceeds 20, so five bits suffice, and
   // every product the gauge forms stays below 4096.
   localparam int QUOT_BITS   = 5;
   localparam int PROD_BITS   = 12;
   localparam int RECIP_BITS  = 14;
   localparam int RECIP_SHIFT = 20;

   // Rounded-up reciprocal of each segment span, scaled by 2^RECIP_SHIFT. The
   // rounding error is too small to change any quotient below 4096 / span.
   localparam logic [RECIP_BITS-1:0] GAUGE_RECIP [GAUGE_POINTS-1] = '{
      14'd6991, 14'd10486, 14'd10486, 14'd10486, 14'd6991, 14'd5243, 14'd6991
   };

   // Queue between the byte parser and the gauge unit.
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic        ok;
      logic [15:0] millivolts;
      logic        charging;
   } job_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_MUL,
      BK_DIV,
      BK_DONE
   } back_state_type;

endpackage

// File: hw/rtl/brt_front.sv
// Byte parser: tracks position, checks the header and hands finished reports on.
module brt_front #(
   parameter int MIN_REPORT_LEN = 20
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_data_byte,
   input  logic             req_last_byte,
   input  logic             queue_full,
   output logic             push,
   output brt_pkg::job_type push_job
);

   localparam logic [5:0] MinLen = 6'(MIN_REPORT_LEN);

   logic [4:0]  pos_ff, pos_in;
   logic        header_ff, header_in;
   logic [15:0] volt_ff, volt_in;
   logic        chg_ff, chg_in;
   logic        hdr_next;
   logic [15:0] volt_next;
   logic        chg_next;
   logic        take;

   assign req_ready = !queue_full;
   assign take      = req_valid && req_ready;

   always_comb begin
      hdr_next  = header_ff;
      volt_next = volt_ff;
      chg_next  = chg_ff;
      case (pos_ff)
         brt_pkg::POS_HEADER: begin
            if (req_data_byte != brt_pkg::HEADER_BYTE) hdr_next = 1'b0;
         end
         brt_pkg::POS_CLASS: begin
            if (req_data_byte != brt_pkg::CLASS_BYTE) hdr_next = 1'b0;
         end
         brt_pkg::POS_KIND: begin
            if (req_data_byte != brt_pkg::KIND_BYTE) hdr_next = 1'b0;
         end
         brt_pkg::POS_VOLT_HI: volt_next = {req_data_byte, volt_ff[7:0]};
         brt_pkg::POS_VOLT_LO: volt_next = {volt_ff[15:8], req_data_byte};
         brt_pkg::POS_STATUS:  chg_next  = (req_data_byte == brt_pkg::CHARGE_BYTE);
         default: ;
      endcase

      push                = take && req_last_byte;
      push_job.ok         = hdr_next && (({1'b0, pos_ff} + 6'd1) >= MinLen);
      push_job.millivolts = volt_next;
      push_job.charging   = chg_next;

      pos_in    = pos_ff;
      header_in = header_ff;
      volt_in   = volt_ff;
      chg_in    = chg_ff;
      if (take) begin
         if (req_last_byte) begin
            pos_in    = '0;
            header_in = 1'b1;
            volt_in   = '0;
            chg_in    = 1'b0;
         end else begin
            pos_in    = (pos_ff < brt_pkg::POS_MAX) ? pos_ff + 5'd1 : pos_ff;
            header_in = hdr_next;
            volt_in   = volt_next;
            chg_in    = chg_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         header_ff <= 1'b1;
         volt_ff   <= '0;
         chg_ff    <= 1'b0;
      end else begin
         pos_ff    <= pos_in;
         header_ff <= header_in;
         volt_ff   <= volt_in;
         chg_ff    <= chg_in;
      end
   end

endmodule

// File: hw/rtl/brt_queue.sv
// Two-entry queue of finished reports between the parser and the gauge unit.
module brt_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  brt_pkg::job_type push_job,
   input  logic             pop,
   output brt_pkg::job_type head_job,
   output logic             empty,
   output logic             full
);

   localparam int PtrBits = $clog2(brt_pkg::QUEUE_DEPTH);
   localparam int CntBits = $clog2(brt_pkg::QUEUE_DEPTH + 1);

   brt_pkg::job_type     entries_ff [brt_pkg::QUEUE_DEPTH];
   logic [PtrBits-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntBits-1:0]   count_ff, count_in;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CntBits'(brt_pkg::QUEUE_DEPTH));
   assign head_job = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrBits'(brt_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrBits'(brt_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// File: hw/rtl/brt_back.sv
// Gauge unit: segment lookup, one multiply and a reciprocal scaling per report.
module brt_back (
   input  logic             clock,
   input  logic             reset,
   input  brt_pkg::job_type head_job,
   input  logic             empty,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic             rsp_translated,
   output logic [6:0]       rsp_percentage,
   output logic             rsp_charging
);

   localparam int ScaledBits = brt_pkg::PROD_BITS + brt_pkg::RECIP_BITS;

   brt_pkg::back_state_type state_ff, state_in;

   logic [6:0]                     base_ff, base_in;
   logic [7:0]                     diff_ff, diff_in;
   logic [4:0]                     prange_ff, prange_in;
   logic [brt_pkg::RECIP_BITS-1:0] recip_ff, recip_in;
   logic [brt_pkg::PROD_BITS-1:0]  prod_ff, prod_in;
   logic [brt_pkg::QUOT_BITS-1:0]  quot_ff, quot_in;
   logic                           ok_ff, ok_in;
   logic                           chg_ff, chg_in;
   logic                           out_valid_ff, out_valid_in;
   logic                           out_trans_ff, out_trans_in;
   logic [6:0]                     out_pct_ff, out_pct_in;
   logic                           out_chg_ff, out_chg_in;

   logic [6:0]                     seg_base;
   logic [7:0]                     seg_diff;
   logic [4:0]                     seg_prange;
   logic [brt_pkg::RECIP_BITS-1:0] seg_recip;
   logic                           seg_found;
   logic [12:0]                    product;
   logic [ScaledBits-1:0]          scaled;
   logic                           out_free;

   assign rsp_valid      = out_valid_ff;
   assign rsp_translated = out_trans_ff;
   assign rsp_percentage = out_pct_ff;
   assign rsp_charging   = out_chg_ff;
   assign out_free       = !out_valid_ff || rsp_ready;

   // Segment lookup: the first breakpoint from the top at or below the voltage wins.
   always_comb begin
      seg_base   = '0;
      seg_diff   = '0;
      seg_prange = '0;
      seg_recip  = '0;
      seg_found  = 1'b0;
      if (head_job.ok) begin
         if (head_job.millivolts >= brt_pkg::GAUGE_MV[0]) begin
            seg_base = brt_pkg::GAUGE_PCT[0];
         end else if (head_job.millivolts > brt_pkg::GAUGE_MV[brt_pkg::GAUGE_POINTS-1]) begin
            for (int i = 0; i < brt_pkg::GAUGE_POINTS - 1; i++) begin
               if (!seg_found && head_job.millivolts >= brt_pkg::GAUGE_MV[i+1]) begin
                  seg_found  = 1'b1;
                  seg_base   = brt_pkg::GAUGE_PCT[i+1];
                  seg_diff   = 8'(head_job.millivolts - brt_pkg::GAUGE_MV[i+1]);
                  seg_prange = 5'(brt_pkg::GAUGE_PCT[i] - brt_pkg::GAUGE_PCT[i+1]);
                  seg_recip  = brt_pkg::GAUGE_RECIP[i];
               end
            end
         end
      end
   end

   assign product = 13'(diff_ff) * 13'(prange_ff);
   assign scaled  = ScaledBits'(prod_ff) * ScaledBits'(recip_ff);

   always_comb begin
      state_in     = state_ff;
      base_in      = base_ff;
      diff_in      = diff_ff;
      prange_in    = prange_ff;
      recip_in     = recip_ff;
      prod_in      = prod_ff;
      quot_in      = quot_ff;
      ok_in        = ok_ff;
      chg_in       = chg_ff;
      pop          = 1'b0;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_trans_in = out_trans_ff;
      out_pct_in   = out_pct_ff;
      out_chg_in   = out_chg_ff;

      case (state_ff)
         brt_pkg::BK_IDLE: begin
            if (!empty) begin
               pop       = 1'b1;
               ok_in     = head_job.ok;
               chg_in    = head_job.ok && head_job.charging;
               base_in   = seg_base;
               diff_in   = seg_diff;
               prange_in = seg_prange;
               recip_in  = seg_recip;
               state_in  = brt_pkg::BK_MUL;
            end
         end
         brt_pkg::BK_MUL: begin
            prod_in  = product[brt_pkg::PROD_BITS-1:0];
            state_in = brt_pkg::BK_DIV;
         end
         brt_pkg::BK_DIV: begin
            // Division by the segment span, done as a multiply by its reciprocal.
            quot_in  = scaled[brt_pkg::RECIP_SHIFT+brt_pkg::QUOT_BITS-1:brt_pkg::RECIP_SHIFT];
            state_in = brt_pkg::BK_DONE;
         end
         brt_pkg::BK_DONE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_trans_in = ok_ff;
               out_pct_in   = base_ff + 7'(quot_ff);
               out_chg_in   = chg_ff;
               state_in     = brt_pkg::BK_IDLE;
            end
         end
         default: state_in = brt_pkg::BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= brt_pkg::BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff      <= base_in;
      diff_ff      <= diff_in;
      prange_ff    <= prange_in;
      recip_ff     <= recip_in;
      prod_ff      <= prod_in;
      quot_ff      <= quot_in;
      ok_ff        <= ok_in;
      chg_ff       <= chg_in;
      out_trans_ff <= out_trans_in;
      out_pct_ff   <= out_pct_in;
      out_chg_ff   <= out_chg_in;
   end

endmodule

// File: hw/rtl/battery_report_translator_core.sv
// Top level of the battery report translator: parser, queue and gauge unit.
//
// Reports arrive one byte per transfer on the req_ channel; req_last_byte marks
// the final byte. Every report gives exactly one transfer on the rsp_ channel:
// rsp_translated is set when the report is long enough and its header bytes
// match, and then rsp_percentage carries the state of charge from an 8-point
// piecewise-linear gauge, with rsp_charging from the status byte.
// Bytes are taken one per cycle while the report queue has room. The final
// byte enters a two-entry queue; the gauge unit then takes it through lookup,
// multiply, reciprocal scaling and output load, and it takes no new report
// from the queue until the output load is done, so the gauge unit, not the
// parser, sets how fast reports are finished.
// If the receiver stalls, the result waits in the output register, the gauge
// unit holds its next result, the queue fills and req_ready then falls.
// A synchronous reset empties the queue, drops rsp_valid and returns the parser
// to the start of a report.
module battery_report_translator_core #(
   parameter int MIN_REPORT_LEN = 20
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_translated,
   output logic [6:0] rsp_percentage,
   output logic       rsp_charging
);

   brt_pkg::job_type push_job;
   brt_pkg::job_type head_job;
   logic             push;
   logic             pop;
   logic             empty;
   logic             full;

   brt_front #(
      .MIN_REPORT_LEN (MIN_REPORT_LEN)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .queue_full    (full),
      .push          (push),
      .push_job      (push_job)
   );

   brt_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .empty    (empty),
      .full     (full)
   );

   brt_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_job       (head_job),
      .empty          (empty),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_translated (rsp_translated),
      .rsp_percentage (rsp_percentage),
      .rsp_charging   (rsp_charging)
   );

endmodule

// File: hw/rtl/brt_checker.sv
// Port-level checks for the battery report translator, bound to the top level.
module brt_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [7:0] req_data_byte,
   input logic       req_last_byte,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_translated,
   input logic [6:0] rsp_percentage,
   input logic       rsp_charging
);

   // No result may be on offer in the cycle after reset.
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered straight after reset");

   // A stalled result keeps its payload.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_translated)
         && $stable(rsp_percentage) && $stable(rsp_charging))
      else $error("stalled result changed");

   // A report that was not translated carries neither charge nor status.
   a_untranslated_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_translated |-> rsp_percentage == 7'd0 && !rsp_charging)
      else $error("untranslated result carries data");

   // The gauge never reports above full charge.
   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_percentage <= 7'd100)
      else $error("percentage out of range");

endmodule

bind battery_report_translator_core brt_checker u_brt_checker (.*);
